### design/irdig_pkg.sv
// ----------------------------------------------------------------------------
// irdig_pkg
// Shared types and constants for the integer to radix digits converter.
// ----------------------------------------------------------------------------
package irdig_pkg;

  // Widths fixed by the item fields.
  localparam int WORD_W  = 32;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;

  // The divider retires this many quotient bits per clock.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = WORD_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
  localparam logic [63:0]        SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0]        SYMBOLS_HIGH_RESET = 64'h4645444342413938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_POP_RD,
    ST_POP_OUT
  } irdig_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the number, clear the digit count
    logic div_step;    // run one divider step
    logic push;        // last divider step: push the remainder digit
    logic pop_rd;      // read the top digit and drop the count
    logic emit_sign;   // present the minus character
    logic emit_digit;  // present the character of the digit just read
  } irdig_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;    // the captured number is negative
    logic quot_zero;   // the quotient of the current step is zero
    logic stack_full;  // the push in progress fills the digit stack
    logic count_zero;  // no digits left on the stack
  } irdig_status_t;

endpackage

### design/irdig_ctrl.sv
// ----------------------------------------------------------------------------
// irdig_ctrl
// Sequencer: runs the divider per digit, then emits sign and digits.
// ----------------------------------------------------------------------------
module irdig_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  irdig_pkg::irdig_status_t status,
  output irdig_pkg::irdig_cmd_t    cmd,
  output logic                    busy
);

  irdig_pkg::irdig_state_t state, state_next;
  logic [irdig_pkg::STEP_W-1:0] step, step_next;
  logic last_step;

  assign last_step = (step == irdig_pkg::STEP_W'(irdig_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irdig_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      irdig_pkg::ST_IDLE: begin
        step_next = '0;
        if (start) state_next = irdig_pkg::ST_DIV;
      end
      irdig_pkg::ST_DIV: begin
        step_next = step + 1'b1;
        if (last_step) begin
          step_next = '0;
          if (status.quot_zero || status.stack_full) begin
            state_next = status.negative ? irdig_pkg::ST_SIGN : irdig_pkg::ST_POP_RD;
          end
        end
      end
      irdig_pkg::ST_SIGN:    state_next = irdig_pkg::ST_POP_RD;
      irdig_pkg::ST_POP_RD:  state_next = irdig_pkg::ST_POP_OUT;
      irdig_pkg::ST_POP_OUT: begin
        state_next = status.count_zero ? irdig_pkg::ST_IDLE : irdig_pkg::ST_POP_RD;
      end
      default: state_next = irdig_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      irdig_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      irdig_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.push     = last_step;
      end
      irdig_pkg::ST_SIGN:    cmd.emit_sign  = 1'b1;
      irdig_pkg::ST_POP_RD:  cmd.pop_rd     = 1'b1;
      irdig_pkg::ST_POP_OUT: cmd.emit_digit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

### design/irdig_dp.sv
// ----------------------------------------------------------------------------
// irdig_dp
// Datapath: magnitude divider, digit stack memory and output register.
// ----------------------------------------------------------------------------
module irdig_dp #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  irdig_pkg::irdig_cmd_t               cmd,
  input  logic signed [irdig_pkg::WORD_W-1:0] number,
  input  logic [irdig_pkg::RADIX_W-1:0]       radix_eff,
  input  logic [63:0]                         symbols_low,
  input  logic [63:0]                         symbols_high,
  output irdig_pkg::irdig_status_t            status,
  output logic [irdig_pkg::CHAR_W-1:0]        out_char,
  output logic                                last,
  output logic                                strobe
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [irdig_pkg::WORD_W-1:0]  mag;
  logic [irdig_pkg::DIGIT_W-1:0] rem;
  logic [CW-1:0]                 count;
  logic                          negative;
  logic [irdig_pkg::DIGIT_W-1:0] stack [MAX_DIGITS];
  logic [irdig_pkg::DIGIT_W-1:0] rd_digit;

  logic [irdig_pkg::WORD_W-1:0]  num_u;
  logic [irdig_pkg::WORD_W-1:0]  mag_step;
  logic [irdig_pkg::DIGIT_W-1:0] rem_step;
  logic [CW-1:0]                 count_inc;
  logic [127:0]                  symbols;
  logic [irdig_pkg::CHAR_W-1:0]  digit_char;

  assign num_u     = number;
  assign count_inc = count + 1'b1;
  assign symbols   = {symbols_high, symbols_low};
  assign digit_char = symbols[{rd_digit, 3'b000} +: irdig_pkg::CHAR_W];

  // Restoring division, DIV_BITS quotient bits per clock. The remainder stays
  // below the radix, so it fits a digit and the trial value fits RADIX_W bits.
  always_comb begin
    logic [irdig_pkg::RADIX_W-1:0] trial;
    logic [irdig_pkg::WORD_W-1:0]  m;
    logic [irdig_pkg::DIGIT_W-1:0] r;
    m = mag;
    r = rem;
    for (int i = 0; i < irdig_pkg::DIV_BITS; i++) begin
      trial = {r, m[irdig_pkg::WORD_W-1]};
      m     = {m[irdig_pkg::WORD_W-2:0], 1'b0};
      if (trial >= radix_eff) begin
        trial = trial - radix_eff;
        m[0]  = 1'b1;
      end
      r = trial[irdig_pkg::DIGIT_W-1:0];
    end
    mag_step = m;
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      negative <= 1'b0;
      rem      <= '0;
    end else if (cmd.load) begin
      negative <= num_u[irdig_pkg::WORD_W-1];
      count    <= '0;
      rem      <= '0;
    end else if (cmd.push) begin
      count <= count_inc;
      rem   <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_step;
    end else if (cmd.pop_rd) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= num_u[irdig_pkg::WORD_W-1] ? (~num_u + 1'b1) : num_u;
    end else if (cmd.div_step) begin
      mag <= mag_step;
    end
  end

  // Digit stack memory.
  always_ff @(posedge clk) begin
    if (cmd.push) stack[count[AW-1:0]] <= rem_step;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_rd) rd_digit <= stack[AW'(count - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= irdig_pkg::MINUS_CHAR;
      last     <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= digit_char;
      last     <= (count == '0);
    end
  end

  assign status.negative   = negative;
  assign status.quot_zero  = (mag_step == '0);
  assign status.stack_full = (count_inc == CW'(MAX_DIGITS));
  assign status.count_zero = (count == '0);

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (count < CW'(MAX_DIGITS)))
    else $error("digit pushed onto a full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> (count != '0))
    else $error("digit popped from an empty stack");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character emitted right after the final one");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count == '0 && rem == '0))
    else $error("load left digit count or remainder set");

endmodule

### design/integer_to_radix_digits_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a signed 32-bit number into its characters in a configurable radix.
// ----------------------------------------------------------------------------
// Sequence: the divider runs once per digit (8 quotient bits per clock over a
//   32-bit magnitude), then a minus sign is emitted if needed, then each digit
//   is read from the stack memory and then registered at the output.
// Throughput: one number at a time; busy rises after the start beat and stays
//   high until the last digit has gone to the output register. The next start
//   beat can be taken in the cycle busy falls.
// The receiver cannot stall; each character is on the ports for one cycle.
// Reset (rst, synchronous) idles the sequencer and restores radix 10 with
//   the symbols "0123456789ABCDEF". No clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
  parameter int MAX_DIGITS = 32,
  parameter int MAX_RADIX  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Command channel: a number is taken when start is high and busy is low.
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [irdig_pkg::WORD_W-1:0]    number,
  // Result channel: one character per strobe, no back pressure.
  output logic                                   strobe,
  output logic [irdig_pkg::CHAR_W-1:0]           out_char,
  output logic                                   last,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [irdig_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [63:0]                            cfg_data
);

  logic [irdig_pkg::RADIX_W-1:0] radix;
  logic [63:0]                   symbols_low;
  logic [63:0]                   symbols_high;
  logic [irdig_pkg::RADIX_W-1:0] radix_eff;

  irdig_pkg::irdig_cmd_t    cmd;
  irdig_pkg::irdig_status_t status;

  // The configuration registers accept a beat in every cycle. Writes to an
  // index beyond the register list complete and are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= irdig_pkg::RADIX_RESET;
      symbols_low  <= irdig_pkg::SYMBOLS_LOW_RESET;
      symbols_high <= irdig_pkg::SYMBOLS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irdig_pkg::CFG_RADIX:        radix        <= cfg_data[irdig_pkg::RADIX_W-1:0];
        irdig_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        irdig_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // The radix saturates into the supported range: below 2 it acts as 2, and
  // above the largest supported radix it acts as that radix.
  always_comb begin
    if (radix < irdig_pkg::RADIX_W'(2)) begin
      radix_eff = irdig_pkg::RADIX_W'(2);
    end else if (radix > irdig_pkg::RADIX_W'(MAX_RADIX)) begin
      radix_eff = irdig_pkg::RADIX_W'(MAX_RADIX);
    end else begin
      radix_eff = radix;
    end
  end

  // The controller walks the divider once per digit (a zero still yields one
  // digit), stops on a zero quotient or a full stack, and then pops the
  // digits most significant first after an optional minus sign.
  irdig_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // When the stack fills, only the least significant MAX_DIGITS digits are
  // kept, which is what the datapath holds.
  irdig_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .number       (number),
    .radix_eff    (radix_eff),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .status       (status),
    .out_char     (out_char),
    .last         (last),
    .strobe       (strobe)
  );

endmodule
